/* rtl/core/fpa_pkg.sv */
// Fixed-point ALU package: opcode and status codes shared by the ALU core and its testbench.
// No dependencies.
`timescale 1ns / 1ps

package fpa_pkg;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_GT       = 4'd4,
		OP_LT       = 4'd5,
		OP_GE       = 4'd6,
		OP_LE       = 4'd7,
		OP_EQ       = 4'd8,
		OP_NE       = 4'd9,
		OP_MAX      = 4'd10,
		OP_MIN      = 4'd11,
		OP_INC      = 4'd12,
		OP_DEC      = 4'd13,
		OP_FROM_INT = 4'd14,
		OP_TO_INT   = 4'd15
	} opcode_t;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK  = 2'd0;
	localparam status_t ST_SAT = 2'd1;
	localparam status_t ST_DIV0 = 2'd2;

	// one result: value, flag, status
	typedef struct packed {
		logic [31:0] value;
		logic        flag;
		status_t     status;
	} result_t;

endpackage

/* rtl/core/fpa_div_step.sv */
// One restoring-division step: shifts in one numerator bit, one quotient bit out.
// No dependencies.
`timescale 1ns / 1ps

module fpa_div_step #(
	parameter int NW = 40
) (
	input  logic [31:0]   rem,
	input  logic [NW-1:0] num,
	input  logic [NW-1:0] quo,
	input  logic [31:0]   den,
	output logic [31:0]   rem_next,
	output logic [NW-1:0] num_next,
	output logic [NW-1:0] quo_next
);

	logic [32:0] trial;
	logic [32:0] diff;
	logic        fits;

	// trial subtract of the divisor
	always_comb begin
		trial    = {rem, num[NW-1]};
		diff     = trial - {1'b0, den};
		fits     = trial >= {1'b0, den};
		rem_next = fits ? diff[31:0] : trial[31:0];
		num_next = {num[NW-2:0], 1'b0};
		quo_next = {quo[NW-2:0], fits};
	end

endmodule

/* rtl/core/fixed_point_alu_core.sv */
// Fixed-point ALU top level: input decode, multiplier, pipelined divider, output register.
// Depends on fpa_pkg and fpa_div_step.
`timescale 1ns / 1ps

// Signed 32-bit fixed-point ALU with FRACTION_BITS fraction bits. One beat in
// per cycle, one result beat out per input beat, in order. Every operation runs
// through the same pipeline, whose length is set by the divider, which resolves
// one quotient bit per stage over 32 + FRACTION_BITS stages. The whole pipeline
// advances whenever the output register is empty or being taken; a stall holds
// every stage in place.
module fixed_point_alu_core #(
	parameter int FRACTION_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // [3:0] opcode, [35:4] operand_a, [67:36] operand_b
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [31:0] result_value, [32] compare_flag, [34:33] status
);

	localparam int NW = 32 + FRACTION_BITS;

	// pipeline advance
	logic en;
	logic out_vld_q;
	fpa_pkg::result_t out_q;

	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {5'd0, out_q.status, out_q.flag, out_q.value};

	// saturate a signed magnitude to 32 bits
	function automatic fpa_pkg::result_t sat_mag(input logic neg, input logic [63:0] m);
		fpa_pkg::result_t r;
		logic [63:0] neg_m;
		neg_m    = ~m + 64'd1;
		r.flag   = 1'b0;
		r.status = fpa_pkg::ST_OK;
		if (neg) begin
			if (m > 64'h0000_0000_8000_0000) begin
				r.value  = 32'h8000_0000;
				r.status = fpa_pkg::ST_SAT;
			end else begin
				r.value = neg_m[31:0];
			end
		end else begin
			if (m > 64'h0000_0000_7FFF_FFFF) begin
				r.value  = 32'h7FFF_FFFF;
				r.status = fpa_pkg::ST_SAT;
			end else begin
				r.value = m[31:0];
			end
		end
		return r;
	endfunction

	// input decode
	fpa_pkg::opcode_t op_in;
	logic signed [31:0] a_in, b_in;
	logic [31:0] ma_in, mb_in;
	fpa_pkg::result_t simple_in;

	assign op_in = fpa_pkg::opcode_t'(s_tdata[3:0]);
	assign a_in  = s_tdata[35:4];
	assign b_in  = s_tdata[67:36];
	assign ma_in = a_in[31] ? (~a_in + 32'd1) : a_in;
	assign mb_in = b_in[31] ? (~b_in + 32'd1) : b_in;

	// operations computed combinationally at the input
	always_comb begin
		logic signed [32:0] ax, bx, s;
		logic signed [63:0] sh;
		logic signed [32:0] ti;
		ax = {a_in[31], a_in};
		bx = {b_in[31], b_in};
		s  = '0;
		sh = '0;
		ti = '0;
		simple_in.value  = '0;
		simple_in.flag   = 1'b0;
		simple_in.status = fpa_pkg::ST_OK;
		unique case (op_in)
			fpa_pkg::OP_ADD, fpa_pkg::OP_SUB, fpa_pkg::OP_INC, fpa_pkg::OP_DEC: begin
				unique case (op_in)
					fpa_pkg::OP_ADD: s = ax + bx;
					fpa_pkg::OP_SUB: s = ax - bx;
					fpa_pkg::OP_INC: s = ax + 33'sd1;
					default:         s = ax - 33'sd1;
				endcase
				if (s[32] != s[31]) begin
					simple_in.value  = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
					simple_in.status = fpa_pkg::ST_SAT;
				end else begin
					simple_in.value = s[31:0];
				end
			end
			fpa_pkg::OP_GT: simple_in.flag = a_in > b_in;
			fpa_pkg::OP_LT: simple_in.flag = a_in < b_in;
			fpa_pkg::OP_GE: simple_in.flag = a_in >= b_in;
			fpa_pkg::OP_LE: simple_in.flag = a_in <= b_in;
			fpa_pkg::OP_EQ: simple_in.flag = a_in == b_in;
			fpa_pkg::OP_NE: simple_in.flag = a_in != b_in;
			fpa_pkg::OP_MAX: begin
				simple_in.flag  = a_in > b_in;
				simple_in.value = (a_in > b_in) ? a_in : b_in;
			end
			fpa_pkg::OP_MIN: begin
				simple_in.flag  = a_in < b_in;
				simple_in.value = (a_in < b_in) ? a_in : b_in;
			end
			fpa_pkg::OP_FROM_INT: begin
				sh = 64'(a_in) <<< FRACTION_BITS;
				if (sh > 64'sh0000_0000_7FFF_FFFF) begin
					simple_in.value  = 32'h7FFF_FFFF;
					simple_in.status = fpa_pkg::ST_SAT;
				end else if (sh < -64'sh0000_0000_8000_0000) begin
					simple_in.value  = 32'h8000_0000;
					simple_in.status = fpa_pkg::ST_SAT;
				end else begin
					simple_in.value = sh[31:0];
				end
			end
			fpa_pkg::OP_TO_INT: begin
				// bias negatives so the shift truncates toward zero
				ti = ax + (a_in[31] ? 33'((34'sd1 <<< FRACTION_BITS) - 34'sd1) : 33'sd0);
				simple_in.value = 32'(ti >>> FRACTION_BITS);
			end
			default: simple_in.value = '0;
		endcase
	end

	// pipeline arrays, entry 0 is the first stage
	logic             vld_s  [0:NW];
	fpa_pkg::opcode_t op_s   [0:NW];
	logic             neg_s  [0:NW];
	logic             bz_s   [0:NW];
	fpa_pkg::result_t side_s [0:NW];
	logic [31:0]      den_s  [0:NW];
	logic [31:0]      rem_s  [0:NW];
	logic [NW-1:0]    num_s  [0:NW];
	logic [NW-1:0]    quo_s  [0:NW];
	logic [31:0]      ma_s1, mb_s1;
	logic [63:0]      prod_s2;

	// first stage capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s[0]   <= op_in;
			neg_s[0]  <= a_in[31] ^ b_in[31];
			bz_s[0]   <= (b_in == 32'sd0);
			side_s[0] <= simple_in;
			den_s[0]  <= mb_in;
			rem_s[0]  <= '0;
			num_s[0]  <= {ma_in, {FRACTION_BITS{1'b0}}};
			quo_s[0]  <= '0;
			ma_s1     <= ma_in;
			mb_s1     <= mb_in;
		end
	end

	// multiplier product, lines up with entry 1
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= ma_s1 * mb_s1;
		end
	end

	// rounded, saturated product
	fpa_pkg::result_t mul_res;
	always_comb begin
		logic [63:0] q;
		q       = (prod_s2 >> FRACTION_BITS) + {63'd0, prod_s2[FRACTION_BITS-1]};
		mul_res = sat_mag(neg_s[1], q);
	end

	// divider stages and side-band delay line
	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [31:0]   rem_n;
		logic [NW-1:0] num_n, quo_n;

		fpa_div_step #(.NW(NW)) u_step (
			.rem      (rem_s[i]),
			.num      (num_s[i]),
			.quo      (quo_s[i]),
			.den      (den_s[i]),
			.rem_next (rem_n),
			.num_next (num_n),
			.quo_next (quo_n)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				op_s[i+1]  <= op_s[i];
				neg_s[i+1] <= neg_s[i];
				bz_s[i+1]  <= bz_s[i];
				den_s[i+1] <= den_s[i];
				rem_s[i+1] <= rem_n;
				num_s[i+1] <= num_n;
				quo_s[i+1] <= quo_n;
				// product joins the side band after rounding
				if (i == 1 && op_s[i] == fpa_pkg::OP_MUL) begin
					side_s[i+1] <= mul_res;
				end else begin
					side_s[i+1] <= side_s[i];
				end
			end
		end
	end

	// divide rounding and final select
	fpa_pkg::result_t fin_res;
	always_comb begin
		logic [NW:0] q;
		logic        up;
		up = {rem_s[NW], 1'b0} >= {1'b0, den_s[NW]};
		q  = {1'b0, quo_s[NW]} + {{NW{1'b0}}, up};
		if (op_s[NW] == fpa_pkg::OP_DIV) begin
			if (bz_s[NW]) begin
				fin_res.value  = '0;
				fin_res.flag   = 1'b0;
				fin_res.status = fpa_pkg::ST_DIV0;
			end else begin
				fin_res = sat_mag(neg_s[NW], 64'(q));
			end
		end else begin
			fin_res = side_s[NW];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_s[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= fin_res;
		end
	end

endmodule

/* test/fixed_point_alu_core_tb.sv */
// Testbench for fixed_point_alu_core: directed and random operand beats, with an
// in-order scoreboard fed by a bit-exact software prediction of each result.
// Depends on fpa_pkg and the fixed_point_alu_core RTL.
`timescale 1ns / 1ps

module fixed_point_alu_core_tb;

	localparam int FRAC = 8;
	localparam int PIPE_DEPTH = 34 + FRAC;
	localparam logic signed [63:0] MAX32 = 64'sd2147483647;
	localparam logic signed [63:0] MIN32 = -64'sd2147483648;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;   // [3:0] opcode, [35:4] operand_a, [67:36] operand_b
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [31:0] result_value, [32] compare_flag, [34:33] status

	fpa_pkg::result_t alu_expected_q[$];
	int               mismatch_count;
	bit               sink_stall_en;

	fixed_point_alu_core #(.FRACTION_BITS(FRAC)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// saturate a wide value to 32 bits
	function automatic logic [31:0] sat32(input logic signed [63:0] v,
			inout fpa_pkg::status_t st);
		if (v > MAX32) begin
			st = fpa_pkg::ST_SAT;
			return MAX32[31:0];
		end
		if (v < MIN32) begin
			st = fpa_pkg::ST_SAT;
			return MIN32[31:0];
		end
		return v[31:0];
	endfunction

	// predicted ALU result for one operation
	function automatic fpa_pkg::result_t alu_predict(input fpa_pkg::opcode_t op,
			input logic signed [31:0] a, input logic signed [31:0] b);
		fpa_pkg::result_t r;
		logic signed [63:0] wa, wb, sq;
		logic [63:0] ma, mb, p, q, n, rem;
		logic neg;
		wa = a;
		wb = b;
		ma = (wa < 0) ? -wa : wa;
		mb = (wb < 0) ? -wb : wb;
		neg = (wa < 0) != (wb < 0);
		r = '0;
		r.status = fpa_pkg::ST_OK;
		case (op)
			fpa_pkg::OP_ADD: r.value = sat32(wa + wb, r.status);
			fpa_pkg::OP_SUB: r.value = sat32(wa - wb, r.status);
			fpa_pkg::OP_MUL: begin
				p = ma * mb;
				q = (p >> FRAC) + {63'd0, p[FRAC-1]};
				sq = neg ? -$signed(q) : $signed(q);
				r.value = sat32(sq, r.status);
			end
			fpa_pkg::OP_DIV: begin
				if (wb == 0) begin
					r.status = fpa_pkg::ST_DIV0;
				end else begin
					n = ma << FRAC;
					q = n / mb;
					rem = n % mb;
					if (rem >= mb - rem) q = q + 64'd1;
					sq = neg ? -$signed(q) : $signed(q);
					r.value = sat32(sq, r.status);
				end
			end
			fpa_pkg::OP_GT: r.flag = wa > wb;
			fpa_pkg::OP_LT: r.flag = wa < wb;
			fpa_pkg::OP_GE: r.flag = wa >= wb;
			fpa_pkg::OP_LE: r.flag = wa <= wb;
			fpa_pkg::OP_EQ: r.flag = wa == wb;
			fpa_pkg::OP_NE: r.flag = wa != wb;
			fpa_pkg::OP_MAX: begin
				r.flag = wa > wb;
				r.value = r.flag ? a : b;
			end
			fpa_pkg::OP_MIN: begin
				r.flag = wa < wb;
				r.value = r.flag ? a : b;
			end
			fpa_pkg::OP_INC: r.value = sat32(wa + 64'sd1, r.status);
			fpa_pkg::OP_DEC: r.value = sat32(wa - 64'sd1, r.status);
			fpa_pkg::OP_FROM_INT: r.value = sat32(wa * (64'sd1 <<< FRAC), r.status);
			default: begin
				sq = wa / (64'sd1 <<< FRAC);
				r.value = sq[31:0];
			end
		endcase
		return r;
	endfunction

	// send one beat, with an optional random gap before it
	task automatic send_op(input fpa_pkg::opcode_t op, input logic [31:0] a,
			input logic [31:0] b, input bit allow_gap);
		int gap;
		if (allow_gap && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'd0, b, a, op};
		alu_expected_q.push_back(alu_predict(op, a, b));
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic idle_source();
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		idle_source();
		while (alu_expected_q.size() != 0) @(posedge clk);
	endtask

	// random operand with a bias toward edge values
	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF - $urandom_range(0, 2);
			1: return 32'h8000_0000 + $urandom_range(0, 2);
			2: return $urandom_range(0, 4) - 2;
			3: return $signed($urandom_range(0, 65535)) - 32768;
			4: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		send_op(fpa_pkg::OP_ADD, 32'h7FFF_FFFF, 32'd1, 0);
		send_op(fpa_pkg::OP_ADD, 32'h8000_0000, 32'hFFFF_FFFF, 0);
		send_op(fpa_pkg::OP_SUB, 32'h8000_0000, 32'd1, 0);
		send_op(fpa_pkg::OP_SUB, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send_op(fpa_pkg::OP_MUL, 32'h0000_0180, 32'hFFFF_FF80, 0);
		send_op(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 0);
		send_op(fpa_pkg::OP_MUL, 32'h0000_0001, 32'h0000_0080, 0);
		send_op(fpa_pkg::OP_DIV, 32'h0000_0100, 32'd0, 0);
		send_op(fpa_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0);
		send_op(fpa_pkg::OP_DIV, 32'hFFFF_FFFF, 32'd3, 0);
		send_op(fpa_pkg::OP_DIV, 32'h0000_0001, 32'h0000_0200, 0);
		send_op(fpa_pkg::OP_GT, 32'd5, 32'hFFFF_FFFB, 0);
		send_op(fpa_pkg::OP_LT, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_op(fpa_pkg::OP_GE, 32'd7, 32'd7, 0);
		send_op(fpa_pkg::OP_LE, 32'd8, 32'd7, 0);
		send_op(fpa_pkg::OP_EQ, 32'd9, 32'd9, 0);
		send_op(fpa_pkg::OP_NE, 32'd9, 32'd9, 0);
		send_op(fpa_pkg::OP_MAX, 32'd3, 32'd3, 0);
		send_op(fpa_pkg::OP_MIN, 32'hFFFF_FFFE, 32'd4, 0);
		send_op(fpa_pkg::OP_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
		send_op(fpa_pkg::OP_DEC, 32'h8000_0000, 32'h0, 0);
		send_op(fpa_pkg::OP_FROM_INT, 32'h0080_0000, 32'd0, 0);
		send_op(fpa_pkg::OP_FROM_INT, 32'hFF7F_FFFF, 32'd0, 0);
		send_op(fpa_pkg::OP_TO_INT, 32'hFFFF_FE80, 32'd0, 0);
		send_op(fpa_pkg::OP_TO_INT, 32'h8000_0000, 32'd0, 0);
		wait_drained();
	endtask

	task automatic test_random(input int count, input bit allow_gap);
		repeat (count)
			send_op(fpa_pkg::opcode_t'($urandom_range(0, 15)), rand_operand(),
				rand_operand(), allow_gap);
	endtask

	// stall the sink in short random bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (sink_stall_en && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		fpa_pkg::result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.value  = m_tdata[31:0];
			got.flag   = m_tdata[32];
			got.status = m_tdata[34:33];
			if (alu_expected_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result beat: %h", got);
			end else begin
				want = alu_expected_q.pop_front();
				if (got.value !== want.value || got.flag !== want.flag
						|| got.status !== want.status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: exp value %h flag %b status %0d, got value %h flag %b status %0d",
							want.value, want.flag, want.status, got.value, got.flag, got.status);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		mismatch_count = 0;
		sink_stall_en = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		sink_stall_en = 1'b1;
		test_random(400, 1);
		// hold off until the pipe has emptied, then resume
		wait_drained();
		test_random(400, 1);
		sink_stall_en = 1'b0;
		test_random(200, 0);
		wait_drained();
		repeat (PIPE_DEPTH + 10) @(posedge clk);
		if (mismatch_count == 0 && alu_expected_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/fpa_pkg.sv
rtl/core/fpa_div_step.sv
rtl/core/fixed_point_alu_core.sv
test/fixed_point_alu_core_tb.sv
